@@ rtl/cmhh_pkg.sv @@
// ----------------------------------------------------------------------------
// cmhh_pkg
// Shared constants for the count-min heavy-hitter detector: field widths,
// default sizes and reset values.
// ----------------------------------------------------------------------------
package cmhh_pkg;

   // default sizes of the sketch rows and the report filter
   localparam int unsigned TABLE_DEPTH_DEF = 64;
   localparam int unsigned COUNT_WIDTH_DEF = 16;

   // number of hash rows (and filter probes) per packet
   localparam int unsigned NUM_ROWS = 3;

   // fixed field widths of the transactions and the control register
   localparam int unsigned IN_INDEX_W = 6;
   localparam int unsigned INST_W     = 8;
   localparam int unsigned THR_W      = 16;
   localparam int unsigned OUT_CNT_W  = 16;

   // number of distinct raw hash index codes
   localparam int unsigned RAW_SPAN = 1 << IN_INDEX_W;

   // instance code of an original (not cloned) packet
   localparam logic [INST_W-1:0] INST_ORIGINAL = '0;

   // threshold after reset, and the saturated reported count
   localparam logic [THR_W-1:0]     THR_RESET = 16'd3;
   localparam logic [OUT_CNT_W-1:0] OUT_MAX   = '1;

endpackage : cmhh_pkg

@@ rtl/cmhh_req_if.sv @@
// ----------------------------------------------------------------------------
// cmhh_req_if
// Packet descriptor channel: valid/ready handshake with flags and the three
// precomputed hash indices.
// ----------------------------------------------------------------------------
interface cmhh_req_if;
   import cmhh_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  is_read;
   logic                  in_cache;
   logic                  entry_valid;
   logic [INST_W-1:0]     clone_instance;
   logic [IN_INDEX_W-1:0] row0_index;
   logic [IN_INDEX_W-1:0] row1_index;
   logic [IN_INDEX_W-1:0] row2_index;

   modport source (
      output valid, is_read, in_cache, entry_valid, clone_instance,
             row0_index, row1_index, row2_index,
      input  ready
   );

   modport sink (
      input  valid, is_read, in_cache, entry_valid, clone_instance,
             row0_index, row1_index, row2_index,
      output ready
   );

endinterface : cmhh_req_if

@@ rtl/cmhh_rsp_if.sv @@
// ----------------------------------------------------------------------------
// cmhh_rsp_if
// Result channel: valid/ready handshake with the per-packet verdict.
// ----------------------------------------------------------------------------
interface cmhh_rsp_if;
   import cmhh_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 read_hit;
   logic                 counted;
   logic [OUT_CNT_W-1:0] min_count;
   logic                 hot_report;

   modport source (
      output valid, read_hit, counted, min_count, hot_report,
      input  ready
   );

   modport sink (
      input  valid, read_hit, counted, min_count, hot_report,
      output ready
   );

endinterface : cmhh_rsp_if

@@ rtl/count_min_heavy_hitter_detector.sv @@
// Pipeline: a request passes through the stage-1 register and then the result register.
// Throughput: one packet per cycle while the result channel is not stalled; the
//   read-modify-write of each sketch row and filter bank uses one-entry write forwarding.
// Reset: synchronous; a clearing pass over all TABLE_DEPTH addresses zeroes all
//   sketch rows and filter banks, with req ready low; threshold resets to 3.
// ----------------------------------------------------------------------------
// count_min_heavy_hitter_detector
// Count-min sketch over three hash rows with a Bloom-filter report
// suppressor. Each original read that misses the cache bumps three
// saturating counters; a minimum at or above the threshold raises one
// hot-key report per filter signature.
// ----------------------------------------------------------------------------
module count_min_heavy_hitter_detector #(
   parameter int unsigned TABLE_DEPTH = cmhh_pkg::TABLE_DEPTH_DEF,
   parameter int unsigned COUNT_WIDTH = cmhh_pkg::COUNT_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [cmhh_pkg::THR_W-1:0] csr_wr_data,
   cmhh_req_if.sink                   req_chan,
   cmhh_rsp_if.source                 rsp_chan
);
   import cmhh_pkg::*;

   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
   localparam int unsigned CMP_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;
   localparam logic [IDX_W-1:0]       LAST_ADDR = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = '1;

   // handshake and control
   logic req_fire;
   logic s1_fire;
   logic hot_fire;

   // threshold register
   logic [THR_W-1:0] thr_ff, thr_in;

   // clearing pass
   logic             clr_busy_ff, clr_busy_in;
   logic [IDX_W-1:0] clr_addr_ff, clr_addr_in;

   // stage 0: index reduction and flags
   logic [IDX_W-1:0] idx_lut [RAW_SPAN];
   logic [IDX_W-1:0] idx_s0  [NUM_ROWS];
   logic             counted_s0;
   logic             read_hit_s0;

   // stage 1: memory data available
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_read_hit_ff, s1_read_hit_in;
   logic             s1_counted_ff, s1_counted_in;
   logic [IDX_W-1:0] s1_idx_ff [NUM_ROWS];
   logic [IDX_W-1:0] s1_idx_in [NUM_ROWS];

   // writes made in the cycle the stage-1 item issued its reads
   logic                   fwd_cnt_en_ff   [NUM_ROWS];
   logic                   fwd_cnt_en_in   [NUM_ROWS];
   logic [IDX_W-1:0]       fwd_cnt_addr_ff [NUM_ROWS];
   logic [IDX_W-1:0]       fwd_cnt_addr_in [NUM_ROWS];
   logic [COUNT_WIDTH-1:0] fwd_cnt_data_ff [NUM_ROWS];
   logic [COUNT_WIDTH-1:0] fwd_cnt_data_in [NUM_ROWS];
   logic                   fwd_hot_ff, fwd_hot_in;
   logic [IDX_W-1:0]       fwd_idx_ff [NUM_ROWS];
   logic [IDX_W-1:0]       fwd_idx_in [NUM_ROWS];

   // memory read data and update values
   logic [COUNT_WIDTH-1:0] row_rd  [NUM_ROWS];
   logic [COUNT_WIDTH-1:0] cur_cnt [NUM_ROWS];
   logic [COUNT_WIDTH-1:0] new_cnt [NUM_ROWS];
   logic                   filt_rd [NUM_ROWS][NUM_ROWS];
   logic                   filt_bit [NUM_ROWS];
   logic                   filt_seen;
   logic [COUNT_WIDTH-1:0] min01;
   logic [COUNT_WIDTH-1:0] min_cnt;
   logic [CMP_W-1:0]       min_ext;
   logic                   thr_hit;
   logic [OUT_CNT_W-1:0]   min_out;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_read_hit_ff, rsp_read_hit_in;
   logic                 rsp_counted_ff, rsp_counted_in;
   logic [OUT_CNT_W-1:0] rsp_min_ff, rsp_min_in;
   logic                 rsp_hot_ff, rsp_hot_in;

   // build the index reduction table at elaboration
   for (genvar g = 0; g < RAW_SPAN; g++) begin : g_lut
      localparam int unsigned MOD_VAL = g % TABLE_DEPTH;
      assign idx_lut[g] = IDX_W'(MOD_VAL);
   end

   // decode the request transaction
   always_comb begin
      idx_s0[0]   = idx_lut[req_chan.row0_index];
      idx_s0[1]   = idx_lut[req_chan.row1_index];
      idx_s0[2]   = idx_lut[req_chan.row2_index];
      read_hit_s0 = req_chan.is_read & req_chan.entry_valid;
      counted_s0  = req_chan.is_read & ~req_chan.in_cache &
                    (req_chan.clone_instance == INST_ORIGINAL);
   end

   // advance stage 1 whenever the result register can take it
   assign s1_fire        = s1_valid_ff & (~rsp_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~clr_busy_ff & (~s1_valid_ff | s1_fire);
   assign req_fire       = req_chan.valid & req_chan.ready;

   // sketch rows: forward, bump with saturation
   for (genvar k = 0; k < NUM_ROWS; k++) begin : g_row
      cmhh_ram #(
         .WIDTH (COUNT_WIDTH),
         .DEPTH (TABLE_DEPTH)
      ) u_row_ram (
         .clock   (clock),
         .wr_en   (clr_busy_ff | (s1_fire & s1_counted_ff)),
         .wr_addr (clr_busy_ff ? clr_addr_ff : s1_idx_ff[k]),
         .wr_data (clr_busy_ff ? '0 : new_cnt[k]),
         .rd_en   (req_fire),
         .rd_addr (idx_s0[k]),
         .rd_data (row_rd[k])
      );

      always_comb begin
         if (fwd_cnt_en_ff[k] && (fwd_cnt_addr_ff[k] == s1_idx_ff[k])) begin
            cur_cnt[k] = fwd_cnt_data_ff[k];
         end else begin
            cur_cnt[k] = row_rd[k];
         end
         new_cnt[k] = (cur_cnt[k] == CNT_MAX) ? cur_cnt[k]
                                              : cur_cnt[k] + COUNT_WIDTH'(1);
      end
   end

   // filter banks: bank [r][w] is probed at index r and set at index w; outside
   // the clearing pass bits only ever get set, so a probe is the OR over the write banks
   for (genvar r = 0; r < NUM_ROWS; r++) begin : g_frd
      for (genvar w = 0; w < NUM_ROWS; w++) begin : g_fwr
         cmhh_ram #(
            .WIDTH (1),
            .DEPTH (TABLE_DEPTH)
         ) u_filt_ram (
            .clock   (clock),
            .wr_en   (clr_busy_ff | hot_fire),
            .wr_addr (clr_busy_ff ? clr_addr_ff : s1_idx_ff[w]),
            .wr_data (~clr_busy_ff),
            .rd_en   (req_fire),
            .rd_addr (idx_s0[r]),
            .rd_data (filt_rd[r][w])
         );
      end

      always_comb begin
         filt_bit[r] = filt_rd[r][0] | filt_rd[r][1] | filt_rd[r][2] |
                       (fwd_hot_ff & ((s1_idx_ff[r] == fwd_idx_ff[0]) |
                                      (s1_idx_ff[r] == fwd_idx_ff[1]) |
                                      (s1_idx_ff[r] == fwd_idx_ff[2])));
      end
   end

   // minimum, threshold test and report decision
   always_comb begin
      min01     = (new_cnt[0] < new_cnt[1]) ? new_cnt[0] : new_cnt[1];
      min_cnt   = (new_cnt[2] < min01) ? new_cnt[2] : min01;
      min_ext   = CMP_W'(min_cnt);
      thr_hit   = (min_ext >= CMP_W'(thr_ff));
      filt_seen = filt_bit[0] & filt_bit[1] & filt_bit[2];
      hot_fire  = s1_fire & s1_counted_ff & thr_hit & ~filt_seen;
      if (min_ext > CMP_W'(OUT_MAX)) begin
         min_out = OUT_MAX;
      end else begin
         min_out = min_ext[OUT_CNT_W-1:0];
      end
   end

   // threshold register
   always_comb begin
      thr_in = csr_wr_en ? csr_wr_data : thr_ff;
   end

   // clearing pass sweeps every address once after reset
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + IDX_W'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   // stage 1 and forwarding capture on each accepted transaction
   always_comb begin
      s1_valid_in    = s1_valid_ff;
      s1_read_hit_in = s1_read_hit_ff;
      s1_counted_in  = s1_counted_ff;
      fwd_hot_in     = fwd_hot_ff;
      for (int k = 0; k < NUM_ROWS; k++) begin
         s1_idx_in[k]       = s1_idx_ff[k];
         fwd_cnt_en_in[k]   = fwd_cnt_en_ff[k];
         fwd_cnt_addr_in[k] = fwd_cnt_addr_ff[k];
         fwd_cnt_data_in[k] = fwd_cnt_data_ff[k];
         fwd_idx_in[k]      = fwd_idx_ff[k];
      end
      if (req_fire) begin
         s1_valid_in    = 1'b1;
         s1_read_hit_in = read_hit_s0;
         s1_counted_in  = counted_s0;
         fwd_hot_in     = hot_fire;
         for (int k = 0; k < NUM_ROWS; k++) begin
            s1_idx_in[k]       = idx_s0[k];
            fwd_cnt_en_in[k]   = s1_fire & s1_counted_ff;
            fwd_cnt_addr_in[k] = s1_idx_ff[k];
            fwd_cnt_data_in[k] = new_cnt[k];
            fwd_idx_in[k]      = s1_idx_ff[k];
         end
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // result register: load from stage 1, drop when taken
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_read_hit_in = rsp_read_hit_ff;
      rsp_counted_in  = rsp_counted_ff;
      rsp_min_in      = rsp_min_ff;
      rsp_hot_in      = rsp_hot_ff;
      if (s1_fire) begin
         rsp_valid_in    = 1'b1;
         rsp_read_hit_in = s1_read_hit_ff;
         rsp_counted_in  = s1_counted_ff;
         rsp_min_in      = s1_counted_ff ? min_out : '0;
         rsp_hot_in      = hot_fire;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THR_RESET;
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_hot_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_ROWS; k++) begin
            fwd_cnt_en_ff[k] <= 1'b0;
         end
      end else begin
         thr_ff       <= thr_in;
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_hot_ff   <= fwd_hot_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < NUM_ROWS; k++) begin
            fwd_cnt_en_ff[k] <= fwd_cnt_en_in[k];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_read_hit_ff  <= s1_read_hit_in;
      s1_counted_ff   <= s1_counted_in;
      rsp_read_hit_ff <= rsp_read_hit_in;
      rsp_counted_ff  <= rsp_counted_in;
      rsp_min_ff      <= rsp_min_in;
      rsp_hot_ff      <= rsp_hot_in;
      for (int k = 0; k < NUM_ROWS; k++) begin
         s1_idx_ff[k]       <= s1_idx_in[k];
         fwd_cnt_addr_ff[k] <= fwd_cnt_addr_in[k];
         fwd_cnt_data_ff[k] <= fwd_cnt_data_in[k];
         fwd_idx_ff[k]      <= fwd_idx_in[k];
      end
   end

   // drive the result transaction
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_hit   = rsp_read_hit_ff;
   assign rsp_chan.counted    = rsp_counted_ff;
   assign rsp_chan.min_count  = rsp_min_ff;
   assign rsp_chan.hot_report = rsp_hot_ff;

endmodule : count_min_heavy_hitter_detector

@@ rtl/cmhh_ram.sv @@
// ----------------------------------------------------------------------------
// cmhh_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// read enable and registered read data (old data on a same-address write).
// ----------------------------------------------------------------------------
module cmhh_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, hold data while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : cmhh_ram

@@ rtl/cmhh_checker.sv @@
// ----------------------------------------------------------------------------
// cmhh_checker
// Port-level checks for the heavy-hitter detector, bound to the top level.
// ----------------------------------------------------------------------------
module cmhh_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_counted,
   input logic [cmhh_pkg::OUT_CNT_W-1:0] rsp_min_count,
   input logic                           rsp_hot_report
);
   import cmhh_pkg::*;

   // requests are held off once reset is seen, as the stores start being cleared
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request accepted during clearing pass");

   // an uncounted packet reports no count and no hot key
   a_uncounted_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_counted) |-> (rsp_min_count == '0 && !rsp_hot_report))
      else $error("uncounted packet carries count or report");

   // a counted packet has a count of at least one
   a_counted_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_counted) |-> (rsp_min_count != '0))
      else $error("counted packet reports zero count");

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

endmodule : cmhh_checker

bind count_min_heavy_hitter_detector cmhh_checker u_cmhh_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_counted    (rsp_chan.counted),
   .rsp_min_count  (rsp_chan.min_count),
   .rsp_hot_report (rsp_chan.hot_report)
);
